// ===== rtl/core/atl_pkg.sv =====
package atl_pkg;

  // Field widths of the channels
  localparam int ADC_W    = 12;
  localparam int TEMP_W   = 9;
  localparam int STATUS_W = 2;

  // Breakpoint table
  localparam int ROM_POINTS = 9;
  localparam int CODE_W     = 12;
  localparam int DEG_W      = TEMP_W;
  localparam int SEG_W      = $clog2(ROM_POINTS);

  // Defaults of the top-level parameters
  localparam int TABLE_POINTS_DEF = 9;
  localparam int SAMPLE_BITS_DEF  = 12;

  typedef enum logic [STATUS_W-1:0] {
    ST_WITHIN = 2'd0,
    ST_BELOW  = 2'd1,
    ST_ABOVE  = 2'd2
  } status_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_NEXT_SEG,
    OP_SETUP,
    OP_MUL,
    OP_DIV,
    OP_SUM,
    OP_CLAMP_LO,
    OP_CLAMP_HI,
    OP_EMIT
  } op_t;

  // Jump conditions; a false condition falls through to the next step
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_BEAT,
    COND_BELOW,
    COND_ABOVE,
    COND_PAST_SEG,
    COND_CNT_NZ,
    COND_OUT_FREE
  } cond_t;

  // Program addresses
  typedef enum logic [3:0] {
    S_FETCH,
    S_CHK_LO,
    S_CHK_HI,
    S_SEARCH,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_SUM,
    S_CLAMP_LO,
    S_CLAMP_HI,
    S_EMIT,
    S_HOLD
  } upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic beat;
    logic below;
    logic above;
    logic past_seg;
    logic cnt_nz;
    logic out_free;
  } flags_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    case (pc)
      S_FETCH:    w = '{op: OP_LATCH,    cond: COND_NO_BEAT,  target: S_FETCH};
      S_CHK_LO:   w = '{op: OP_NOP,      cond: COND_BELOW,    target: S_CLAMP_LO};
      S_CHK_HI:   w = '{op: OP_NOP,      cond: COND_ABOVE,    target: S_CLAMP_HI};
      S_SEARCH:   w = '{op: OP_NEXT_SEG, cond: COND_PAST_SEG, target: S_SEARCH};
      S_SETUP:    w = '{op: OP_SETUP,    cond: COND_NONE,     target: S_FETCH};
      S_MUL:      w = '{op: OP_MUL,      cond: COND_NONE,     target: S_FETCH};
      S_DIV:      w = '{op: OP_DIV,      cond: COND_CNT_NZ,   target: S_DIV};
      S_SUM:      w = '{op: OP_SUM,      cond: COND_ALWAYS,   target: S_EMIT};
      S_CLAMP_LO: w = '{op: OP_CLAMP_LO, cond: COND_ALWAYS,   target: S_EMIT};
      S_CLAMP_HI: w = '{op: OP_CLAMP_HI, cond: COND_NONE,     target: S_FETCH};
      S_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_FREE, target: S_FETCH};
      S_HOLD:     w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: S_EMIT};
      default:    w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: S_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [CODE_W-1:0] rom_code(logic [SEG_W-1:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      4'd0:    c = 12'd788;
      4'd1:    c = 12'd1124;
      4'd2:    c = 12'd1380;
      4'd3:    c = 12'd1634;
      4'd4:    c = 12'd1860;
      4'd5:    c = 12'd2106;
      4'd6:    c = 12'd2298;
      4'd7:    c = 12'd2454;
      4'd8:    c = 12'd2550;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [DEG_W-1:0] rom_deg(logic [SEG_W-1:0] idx);
    logic [DEG_W-1:0] d;
    case (idx)
      4'd0:    d = 9'd15;
      4'd1:    d = 9'd85;
      4'd2:    d = 9'd150;
      4'd3:    d = 9'd220;
      4'd4:    d = 9'd285;
      4'd5:    d = 9'd350;
      4'd6:    d = 9'd400;
      4'd7:    d = 9'd442;
      4'd8:    d = 9'd482;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/adc_to_temperature_linearizer.sv =====
// Channel   Ports                                           Direction
// input     in_valid, in_stall, in_adc_sample               sample in
// result    out_valid, out_stall, out_temperature,          temperature out
//           out_range_status
//
// A small microprogram runs one sample at a time. A sample clamped below or
// above goes straight to its clamp step; an interpolated one runs a segment
// scan of up to 8 steps plus a 9-step restoring divide. in_stall is low only
// in the fetch step.
// Reset (rst_n, synchronous) returns the program counter to fetch and
// empties the output register. A stalled result holds in the output
// register; the sequencer waits in its emit and hold steps until it is free.
module adc_to_temperature_linearizer #(
  parameter int TABLE_POINTS = atl_pkg::TABLE_POINTS_DEF,
  parameter int SAMPLE_BITS  = atl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [atl_pkg::ADC_W-1:0]     in_adc_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [atl_pkg::TEMP_W-1:0]    out_temperature,
  output logic [atl_pkg::STATUS_W-1:0]  out_range_status
);
  import atl_pkg::*;

  localparam int UsedPoints = (TABLE_POINTS < 2) ? 2 :
                              ((TABLE_POINTS < ROM_POINTS) ? TABLE_POINTS : ROM_POINTS);
  localparam logic [SEG_W-1:0] LastIdx = SEG_W'(UsedPoints - 1);
  localparam logic [ADC_W-1:0] SampleMask =
    (SAMPLE_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam int PROD_W = CODE_W + DEG_W;
  localparam int CNT_W  = $clog2(DEG_W);

  op_t    op;
  flags_t flags;

  logic [ADC_W-1:0]  x_r;
  logic [SEG_W-1:0]  k_r;
  logic [CODE_W-1:0] diff_r;
  logic [DEG_W-1:0]  dt_r;
  logic [CODE_W-1:0] den_r;
  logic [DEG_W-1:0]  base_r;
  logic [CODE_W-1:0] rem_r;
  logic [DEG_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DEG_W-1:0]  res_temp_r;
  status_t           res_status_r;
  logic              out_valid_r;
  logic [DEG_W-1:0]  out_temp_r;
  status_t           out_status_r;

  logic [SEG_W-1:0]  k_next;
  logic [CODE_W-1:0] code_k;
  logic [CODE_W-1:0] code_k1;
  logic [DEG_W-1:0]  deg_k;
  logic [DEG_W-1:0]  deg_k1;
  logic [PROD_W-1:0] prod;
  logic [CODE_W:0]   rem_sh;
  logic [CODE_W:0]   rem_sub;
  logic              rem_ge;
  logic              beat;
  logic              out_free;

  atl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  assign in_stall = (op != OP_LATCH);
  assign beat     = in_valid && (op == OP_LATCH);
  assign out_free = !out_valid_r || !out_stall;

  assign k_next  = k_r + SEG_W'(1);
  assign code_k  = rom_code(k_r);
  assign code_k1 = rom_code(k_next);
  assign deg_k   = rom_deg(k_r);
  assign deg_k1  = rom_deg(k_next);

  assign prod    = PROD_W'(diff_r) * PROD_W'(dt_r);
  // one restoring divide step; remainder stays below den_r
  assign rem_sh  = {rem_r, quo_r[DEG_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign rem_ge  = (rem_sh >= {1'b0, den_r});

  always_comb begin
    flags.beat     = beat;
    flags.below    = (x_r < rom_code(SEG_W'(0)));
    flags.above    = (x_r > rom_code(LastIdx));
    flags.past_seg = (x_r > code_k1);
    flags.cnt_nz   = (cnt_r != '0);
    flags.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        if (in_valid) begin
          x_r <= in_adc_sample & SampleMask;
          k_r <= '0;
        end
      end
      OP_NEXT_SEG: begin
        if (x_r > code_k1) begin
          k_r <= k_next;
        end
      end
      OP_SETUP: begin
        diff_r <= x_r - code_k;
        dt_r   <= deg_k1 - deg_k;
        den_r  <= code_k1 - code_k;
        base_r <= deg_k;
      end
      OP_MUL: begin
        // quotient is at most dt_r, so the high part is already below den_r
        rem_r <= prod[PROD_W-1:DEG_W];
        quo_r <= prod[DEG_W-1:0];
        cnt_r <= CNT_W'(DEG_W - 1);
      end
      OP_DIV: begin
        rem_r <= rem_ge ? rem_sub[CODE_W-1:0] : rem_sh[CODE_W-1:0];
        quo_r <= {quo_r[DEG_W-2:0], rem_ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      OP_SUM: begin
        res_temp_r   <= base_r + quo_r;
        res_status_r <= ST_WITHIN;
      end
      OP_CLAMP_LO: begin
        res_temp_r   <= rom_deg(SEG_W'(0));
        res_status_r <= ST_BELOW;
      end
      OP_CLAMP_HI: begin
        res_temp_r   <= rom_deg(LastIdx);
        res_status_r <= ST_ABOVE;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_temp_r   <= res_temp_r;
          out_status_r <= res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temperature  = out_temp_r;
  assign out_range_status = out_status_r;

endmodule

// ===== rtl/core/atl_seq.sv =====
module atl_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  atl_pkg::flags_t flags,
  output atl_pkg::op_t    op
);
  import atl_pkg::*;

  upc_t   pc_r;
  upc_t   pc_nxt;
  uword_t uw;
  logic   taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uw = ucode(pc_r);
    case (uw.cond)
      COND_NONE:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_BEAT:  taken = !flags.beat;
      COND_BELOW:    taken = flags.below;
      COND_ABOVE:    taken = flags.above;
      COND_PAST_SEG: taken = flags.past_seg;
      COND_CNT_NZ:   taken = flags.cnt_nz;
      COND_OUT_FREE: taken = flags.out_free;
      default:       taken = 1'b0;
    endcase
    pc_nxt = taken ? uw.target : upc_t'(pc_r + 4'd1);
    op     = uw.op;
  end

endmodule

// ===== verif/adc_to_temperature_linearizer_tb.sv =====
`timescale 1ns / 100ps

module adc_to_temperature_linearizer_tb;
  import atl_pkg::*;

  localparam int POINTS      = (TABLE_POINTS_DEF < 2) ? 2 :
                               ((TABLE_POINTS_DEF < ROM_POINTS) ? TABLE_POINTS_DEF : ROM_POINTS);
  localparam int SAMPLE_MASK = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int RAND_ITEMS  = 930;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic [TEMP_W-1:0] temp;
    status_t           status;
  } reading_t;

  typedef struct {
    logic [ADC_W-1:0]  sample;
    bit                fixed;
    logic [TEMP_W-1:0] temp;
    status_t           status;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ADC_W-1:0]    in_adc_sample;
  logic                out_valid;
  logic                out_stall;
  logic [TEMP_W-1:0]   out_temperature;
  logic [STATUS_W-1:0] out_range_status;

  // breakpoints of the linearization curve: (code, degrees)
  int bp_code [ROM_POINTS] = '{788, 1124, 1380, 1634, 1860, 2106, 2298, 2454, 2550};
  int bp_deg  [ROM_POINTS] = '{15, 85, 150, 220, 285, 350, 400, 442, 482};

  dir_row_t dir_rows [20] = '{
    '{12'd0,    1'b1, 9'd15,  ST_BELOW},
    '{12'd787,  1'b1, 9'd15,  ST_BELOW},
    '{12'd788,  1'b1, 9'd15,  ST_WITHIN},
    '{12'd789,  1'b0, 9'd0,   ST_WITHIN},
    '{12'd1123, 1'b0, 9'd0,   ST_WITHIN},
    '{12'd1124, 1'b1, 9'd85,  ST_WITHIN},
    '{12'd1125, 1'b0, 9'd0,   ST_WITHIN},
    '{12'd1380, 1'b1, 9'd150, ST_WITHIN},
    '{12'd1365, 1'b0, 9'd0,   ST_WITHIN},
    '{12'd1634, 1'b1, 9'd220, ST_WITHIN},
    '{12'd1860, 1'b1, 9'd285, ST_WITHIN},
    '{12'd2048, 1'b0, 9'd0,   ST_WITHIN},
    '{12'd2106, 1'b1, 9'd350, ST_WITHIN},
    '{12'd2298, 1'b1, 9'd400, ST_WITHIN},
    '{12'd2454, 1'b1, 9'd442, ST_WITHIN},
    '{12'd2549, 1'b0, 9'd0,   ST_WITHIN},
    '{12'd2550, 1'b1, 9'd482, ST_WITHIN},
    '{12'd2551, 1'b1, 9'd482, ST_ABOVE},
    '{12'd2730, 1'b1, 9'd482, ST_ABOVE},
    '{12'd4095, 1'b1, 9'd482, ST_ABOVE}
  };

  reading_t pending_readings [$];
  int       error_count;
  int       idle_cycles;
  bit       no_idle;

  adc_to_temperature_linearizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_temperature  (out_temperature),
    .out_range_status (out_range_status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic reading_t linearize(input logic [ADC_W-1:0] raw);
    reading_t r;
    int       x;
    int       lo;
    int       hi;
    int       den;
    bit       found;
    x        = int'(raw) & SAMPLE_MASK;
    r.temp   = '0;
    r.status = ST_WITHIN;
    found    = 1'b0;
    if (x < bp_code[0]) begin
      r.temp   = TEMP_W'(bp_deg[0]);
      r.status = ST_BELOW;
    end else if (x > bp_code[POINTS-1]) begin
      r.temp   = TEMP_W'(bp_deg[POINTS-1]);
      r.status = ST_ABOVE;
    end else begin
      for (int k = 0; k < POINTS - 1; k++) begin
        lo = bp_code[k];
        hi = bp_code[k+1];
        if (!found && ((x >= lo && x <= hi) || (x >= hi && x <= lo))) begin
          found = 1'b1;
          den   = hi - lo;
          if (den == 0)
            r.temp = TEMP_W'(bp_deg[k]);
          else
            r.temp = TEMP_W'(bp_deg[k] + (x - lo) * (bp_deg[k+1] - bp_deg[k]) / den);
        end
      end
    end
    return r;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_sample(input logic [ADC_W-1:0] s, input reading_t expected);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(expected);
    @(negedge clk);
  endtask

  // result side: stall for a drawn number of cycles once a beat is offered
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (n - 1) @(posedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected beat: temperature %0d range_status %0d",
               out_temperature, out_range_status);
        error_count++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (out_temperature !== exp_r.temp) begin
          $error("temperature: expected %0d, actual %0d", exp_r.temp, out_temperature);
          error_count++;
        end
        if (out_range_status !== exp_r.status) begin
          $error("range_status: expected %0d, actual %0d", exp_r.status, out_range_status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    reading_t         r;
    logic [ADC_W-1:0] s;
    int               pick;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_adc_sample = '0;
    no_idle       = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].fixed) begin
        r.temp   = dir_rows[i].temp;
        r.status = dir_rows[i].status;
      end else begin
        r = linearize(dir_rows[i].sample);
      end
      send_sample(dir_rows[i].sample, r);
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // every fourth stretch of items runs back to back on both sides
      no_idle = ((i / 120) % 4) == 3;
      pick = $urandom_range(0, 99);
      if (pick < 60)
        s = ADC_W'($urandom_range(788, 2550));
      else if (pick < 80)
        s = ADC_W'(bp_code[$urandom_range(0, ROM_POINTS - 1)] + $urandom_range(0, 4) - 2);
      else
        s = ADC_W'($urandom_range(0, 4095));
      send_sample(s, linearize(s));
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/atl_pkg.sv
rtl/core/atl_seq.sv
rtl/core/adc_to_temperature_linearizer.sv
verif/adc_to_temperature_linearizer_tb.sv
